// File: hdl/color_space_converter_assert.svh
`ifndef COLOR_SPACE_CONVERTER_ASSERT_SVH
`define COLOR_SPACE_CONVERTER_ASSERT_SVH
// Assertion helpers used by the converter module.
`define CSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/csc_pkg.sv
package csc_pkg;
	localparam int COEF_FRAC_BITS = 14;
	localparam int CW = COEF_FRAC_BITS + 3;
	localparam int SW = COEF_FRAC_BITS + 12;

	typedef enum logic [1:0] {
		MODE_RGB2HSV = 2'd0,
		MODE_HSV2BGR = 2'd1,
		MODE_RGB2YUV = 2'd2,
		MODE_YUV2BGR = 2'd3
	} mode_t;

	localparam logic [0:0] CFG_MODE  = 1'b0;
	localparam logic [0:0] CFG_ORDER = 1'b1;

	function automatic logic signed [CW-1:0] coef(input int milli);
		longint m;
		longint v;
		begin
			m = (milli < 0) ? -milli : milli;
			v = ((m * (longint'(1) << COEF_FRAC_BITS)) + 500) / 1000;
			coef = CW'((milli < 0) ? -v : v);
		end
	endfunction

	// truncate toward zero, saturate 0..255
	function automatic logic [7:0] sat_trunc(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] a;
		logic signed [SW-1:0] q;
		begin
			a = (s < 0) ? -s : s;
			q = a >>> COEF_FRAC_BITS;
			if (s < 0) sat_trunc = 8'd0;
			else if (q > 255) sat_trunc = 8'd255;
			else sat_trunc = q[7:0];
		end
	endfunction

	typedef struct packed {
		logic        vld;
		mode_t       mode;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
	} stage_t;
endpackage

// File: hdl/csc_core.sv
// Four-stage datapath with a shared enable. Stage 1: operands and products;
// stage 2: sums, divisions set up; stage 3: quotient by reciprocal; stage 4: correction and select.
module csc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  csc_pkg::stage_t     in_s0,
	input  logic                order,
	output csc_pkg::stage_t     out_s4
);
	import csc_pkg::*;

	// ---------------- stage 1 ----------------
	stage_t  st_s1;
	logic [7:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [1:0] hsel_s1;
	logic [2:0] sec_s1;
	logic [15:0] vs_s1;
	logic [12:0] rs_s1, trs_s1;
	logic signed [SW-1:0] y_s1, u_s1, v_s1;

	logic [7:0] r0, g0, b0, mx0, mn0;
	logic [7:0] h0;
	logic [2:0] sec0;
	logic signed [9:0] uu, vv;
	always_comb begin
		g0 = in_s0.b;
		r0 = order ? in_s0.c : in_s0.a;
		b0 = order ? in_s0.a : in_s0.c;
		mx0 = r0; mn0 = r0;
		if (g0 > mx0) mx0 = g0;
		if (g0 < mn0) mn0 = g0;
		if (b0 > mx0) mx0 = b0;
		if (b0 < mn0) mn0 = b0;
		h0 = in_s0.a;
		sec0 = (h0 >= 8'd180) ? 3'd6 : (h0 >= 8'd150) ? 3'd5 : (h0 >= 8'd120) ? 3'd4 :
			(h0 >= 8'd90) ? 3'd3 : (h0 >= 8'd60) ? 3'd2 : (h0 >= 8'd30) ? 3'd1 : 3'd0;
		uu = $signed({2'b0, in_s0.b}) - 10'sd128;
		vv = $signed({2'b0, in_s0.c}) - 10'sd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (adv) begin
			st_s1 <= in_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= r0; g_s1 <= g0; b_s1 <= b0; mx_s1 <= mx0; mn_s1 <= mn0;
			hsel_s1 <= (mx0 == r0) ? 2'd0 : (mx0 == g0) ? 2'd1 : 2'd2;
			sec_s1 <= sec0;
			vs_s1 <= in_s0.c * (8'd255 - in_s0.b);
			rs_s1 <= 13'(5'(h0 - 8'(sec0 * 30)) * in_s0.b);
			trs_s1 <= 13'((5'd30 - 5'(h0 - 8'(sec0 * 30))) * in_s0.b);
			if (in_s0.mode == MODE_RGB2YUV) begin
				y_s1 <= SW'(coef(299) * $signed({1'b0, r0})) + SW'(coef(587) * $signed({1'b0, g0}))
					+ SW'(coef(114) * $signed({1'b0, b0}));
				u_s1 <= (SW'(128) <<< COEF_FRAC_BITS) + SW'(coef(-169) * $signed({1'b0, r0}))
					+ SW'(coef(-331) * $signed({1'b0, g0})) + SW'(coef(500) * $signed({1'b0, b0}));
				v_s1 <= (SW'(128) <<< COEF_FRAC_BITS) + SW'(coef(500) * $signed({1'b0, r0}))
					+ SW'(coef(-419) * $signed({1'b0, g0})) + SW'(coef(-81) * $signed({1'b0, b0}));
			end else begin
				y_s1 <= (SW'(in_s0.a) <<< COEF_FRAC_BITS) + SW'(coef(1770) * uu);
				u_s1 <= (SW'(in_s0.a) <<< COEF_FRAC_BITS) + SW'(coef(-343) * uu)
					+ SW'(coef(-714) * vv);
				v_s1 <= (SW'(in_s0.a) <<< COEF_FRAC_BITS) + SW'(coef(1403) * vv);
			end
		end
	end

	// ---------------- stage 2 ----------------
	// hue numerator in half-degrees domain: hue2 = num/(2d); divide by table reciprocal
	stage_t st_s2;
	logic [7:0] mx_s2, dd_s2;
	logic [16:0] hn_s2;      // nonnegative even numerator, < 360*255
	logic [16:0] sn_s2;      // d*255
	logic [7:0] p_s2;
	logic [23:0] qn_s2, tn_s2;
	logic [2:0] sec_s2;
	logic [7:0] y_s2, u_s2, v_s2;

	logic [7:0] d1;
	logic signed [18:0] num1;
	always_comb begin
		d1 = mx_s1 - mn_s1;
		case (hsel_s1)
			2'd0: num1 = 19'sd60 * ($signed({11'b0, g_s1}) - $signed({11'b0, b_s1}));
			2'd1: num1 = 19'sd120 * $signed({11'b0, d1})
				+ 19'sd60 * ($signed({11'b0, b_s1}) - $signed({11'b0, r_s1}));
			default: num1 = 19'sd240 * $signed({11'b0, d1})
				+ 19'sd60 * ($signed({11'b0, r_s1}) - $signed({11'b0, g_s1}));
		endcase
		if (num1 < 0) num1 = num1 + 19'sd360 * $signed({11'b0, d1});
	end

	// v*(255-s)/255 with x<65536: (x*257+257)>>16 exact
	logic [15:0] pn1;
	assign pn1 = vs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_s2 <= '0;
		else if (adv) st_s2 <= st_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2 <= mx_s1;
			dd_s2 <= d1;
			hn_s2 <= 17'(num1);
			sn_s2 <= 17'(d1 * 9'd255);
			p_s2 <= 8'((25'(pn1) * 25'd257 + 25'd257) >> 16);
			qn_s2 <= 24'(st_s1.c * (13'd7650 - rs_s1));
			tn_s2 <= 24'(st_s1.c * (13'd7650 - trs_s1));
			sec_s2 <= sec_s1;
			y_s2 <= sat_trunc(y_s1);
			u_s2 <= sat_trunc(u_s1);
			v_s2 <= sat_trunc(v_s1);
		end
	end

	// ---------------- stage 3 ----------------
	// division by 8-bit divisor: reciprocal estimate then one correction in stage 4
	localparam int RB = 26;
	logic [RB-1:0] rc_tab [256];
	for (genvar gi = 0; gi < 256; gi++) begin : g_rc
		localparam logic [RB-1:0] RC =
			RB'(((longint'(1) << RB) + gi - 1) / ((gi == 0) ? 1 : gi));
		assign rc_tab[gi] = RC;
	end

	stage_t st_s3;
	logic [17:0] hq_s3, sq_s3;
	logic [16:0] hn_s3, sn_s3;
	logic [8:0] hd_s3;
	logic [7:0] sd_s3, p_s3, qq_s3, tt_s3, y_s3, u_s3, v_s3;
	logic [2:0] sec_s3;
	logic gray_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_s3 <= '0;
		else if (adv) st_s3 <= st_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// numerator is even: num/(2d) == (num/2)/d
			hq_s3 <= 18'((44'(hn_s2[16:1]) * 44'(rc_tab[dd_s2])) >> RB);
			sq_s3 <= 18'((44'(sn_s2) * 44'(rc_tab[mx_s2])) >> RB);
			hn_s3 <= {1'b0, hn_s2[16:1]}; sn_s3 <= sn_s2;
			hd_s3 <= {1'b0, dd_s2};
			sd_s3 <= mx_s2;
			gray_s3 <= (dd_s2 == 8'd0);
			p_s3 <= p_s2;
			// x/7650 exact for x < 2^21
			qq_s3 <= 8'((48'(qn_s2) * 48'd2245735) >> 34);
			tt_s3 <= 8'((48'(tn_s2) * 48'd2245735) >> 34);
			sec_s3 <= sec_s2;
			y_s3 <= y_s2; u_s3 <= u_s2; v_s3 <= v_s2;
		end
	end

	// ---------------- stage 4 ----------------
	logic [7:0] h4, s4, o1, o2, o3;
	logic [7:0] hq_c, sq_c;
	always_comb begin
		// reciprocal rounded up: estimate may exceed by one
		hq_c = (27'(hq_s3) * 27'(hd_s3) > 27'(hn_s3)) ? 8'(hq_s3 - 1) : 8'(hq_s3);
		sq_c = (26'(sq_s3) * 26'(sd_s3) > 26'(sn_s3)) ? 8'(sq_s3 - 1) : 8'(sq_s3);
		h4 = gray_s3 ? 8'd0 : hq_c;
		s4 = (sd_s3 == 0) ? 8'd0 : sq_c;
		o1 = '0; o2 = '0; o3 = '0;
		case (st_s3.mode)
			MODE_RGB2HSV: begin o1 = h4; o2 = s4; o3 = sd_s3; end
			MODE_HSV2BGR: begin
				case (sec_s3)
					3'd0: begin o1 = p_s3; o2 = tt_s3; o3 = st_s3.c; end
					3'd1: begin o1 = p_s3; o2 = st_s3.c; o3 = qq_s3; end
					3'd2: begin o1 = tt_s3; o2 = st_s3.c; o3 = p_s3; end
					3'd3: begin o1 = st_s3.c; o2 = qq_s3; o3 = p_s3; end
					3'd4: begin o1 = st_s3.c; o2 = p_s3; o3 = tt_s3; end
					3'd5: begin o1 = qq_s3; o2 = p_s3; o3 = st_s3.c; end
					default: begin o1 = st_s3.a; o2 = st_s3.b; o3 = st_s3.c; end
				endcase
			end
			default: begin o1 = y_s3; o2 = u_s3; o3 = v_s3; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_s4 <= '0;
		else if (adv) out_s4 <= '{vld: st_s3.vld, mode: st_s3.mode, a: o1, b: o2, c: o3};
	end
endmodule

// File: hdl/color_space_converter.sv
// Pipeline: four register stages; an input is registered through st_s1, st_s2, st_s3 and out_s4 in turn.
// Throughput: one pixel per clock unless stalled; a stall freezes every stage together.
// Input ready follows output: the pipe advances when the output is empty or taken.
// Reset: arst_n clears all valid bits, conversion_mode and channel_order to 0.
`include "color_space_converter_assert.svh"
module color_space_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_first,
	input  logic [7:0] in_second,
	input  logic [7:0] in_third,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_first,
	output logic [7:0] out_second,
	output logic [7:0] out_third
);
	import csc_pkg::*;

	mode_t mode_q;
	logic  order_q;
	logic  adv;
	stage_t in_s0, res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RGB2HSV;
			order_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODE) mode_q <= mode_t'(cfg_data);
			else order_q <= cfg_data[0];
		end
	end

	assign adv = !(res_s4.vld && out_stall);
	assign in_stall = !adv;

	always_comb begin
		in_s0.vld = in_valid;
		in_s0.mode = mode_q;
		in_s0.a = in_first;
		in_s0.b = in_second;
		in_s0.c = in_third;
	end

	csc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_s0  (in_s0),
		.order  (order_q),
		.out_s4 (res_s4)
	);

	assign out_valid  = res_s4.vld;
	assign out_first  = res_s4.a;
	assign out_second = res_s4.b;
	assign out_third  = res_s4.c;

	`CSC_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_first), "held result lost")
	`CSC_ASSERT(a_stall, in_stall |-> out_valid && out_stall, "stall without backpressure")
	`CSC_ASSERT_RST(a_rst, !arst_n |-> !out_valid, "valid during reset")
endmodule
